// ===== rtl/ffha_pkg.sv =====
// Shared types and constants for the first-fit halving allocator.
package ffha_pkg;

  // Byte sizes and offsets are 16 bits wide
  typedef logic [15:0] ffha_word_t;

  // Heap size after reset
  localparam ffha_word_t HEAP_RESET = 16'd1024;

  // Outcome of examining one block
  typedef struct packed {
    logic grant;  // take this block
    logic split;  // halve it and look again
    logic skip;   // move on along the chain
  } ffha_dec_t;

endpackage

// ===== rtl/ffha_if.sv =====
// Valid/ready channel interfaces for request, result and configuration words.
interface ffha_req_if;
  import ffha_pkg::*;
  logic       valid;
  logic       ready;
  ffha_word_t request_size;
  modport source (output valid, output request_size, input ready);
  modport sink   (input valid, input request_size, output ready);
endinterface

interface ffha_rsp_if;
  import ffha_pkg::*;
  logic       valid;
  logic       ready;
  logic       granted;
  ffha_word_t data_offset;
  modport source (output valid, output granted, output data_offset, input ready);
  modport sink   (input valid, input granted, input data_offset, output ready);
endinterface

interface ffha_cfg_if;
  import ffha_pkg::*;
  logic       valid;
  logic       ready;
  ffha_word_t pool_bytes;
  modport source (output valid, output pool_bytes, input ready);
  modport sink   (input valid, input pool_bytes, output ready);
endinterface

// ===== rtl/ffha_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ffha_eval.sv =====
// Block examination: fit test, half size and grant/split/skip decision.
module ffha_eval #(
  parameter int HEADER_BYTES = 16
) (
  input  ffha_pkg::ffha_word_t size,
  input  logic                 used,
  input  ffha_pkg::ffha_word_t req,
  input  logic                 table_full,
  output ffha_pkg::ffha_word_t half,
  output ffha_pkg::ffha_dec_t  dec
);
  import ffha_pkg::*;

  logic [16:0] diff;
  logic        splittable;
  logic        exact;
  logic        larger;
  logic        whole;

  // Halving: (size - header) / 2, positive only when size exceeds header + 1
  assign diff       = {1'b0, size} - 17'(HEADER_BYTES);
  assign splittable = ({1'b0, size} > (17'(HEADER_BYTES) + 17'd1));
  assign half       = splittable ? diff[16:1] : '0;

  assign exact = (size == req);
  assign larger = (size > req);
  // Larger block taken whole when it cannot be halved usefully or the table is full
  assign whole = !splittable || (half < req) || table_full;

  always_comb begin
    dec.grant = !used && (exact || (larger && whole));
    dec.split = !used && larger && !whole;
    dec.skip  = !(dec.grant || dec.split);
  end

endmodule

// ===== rtl/first_fit_halving_allocator_top.sv =====
// Top level of the first-fit halving allocator: control sequencer and block table.
//
// Usage: requests arrive on in_ch (request_size, one word each) and each yields
// exactly one result word on out_ch: granted and data_offset (header offset plus
// the header size; zero when nothing fits). cfg_ch writes pool_bytes and resets
// the block table to a single free block of that size.
// Sequencing: the table sits in one RAM with a registered read, so every block
// visited on the chain passes through ST_READ (address), then ST_EVAL. A split
// adds ST_SPLIT, which writes the new upper half, and then re-reads the same
// block through ST_READ and ST_EVAL. ST_RESP loads the result register, and
// the next request can be taken in the cycle after the result is loaded.
// Reset: rst_n (synchronous, active low) restores pool_bytes to 1024; ST_INIT
// then rewrites table entry 0 before in_ch and cfg_ch go ready. A pool_bytes
// write passes through the same ST_INIT state.
// Stalls: the result waits in an output register; a new request is accepted
// meanwhile, and a later result holds in the sequencer until the register frees.
module first_fit_halving_allocator_top #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16
) (
  input logic      clk,
  input logic      rst_n,
  ffha_req_if.sink   in_ch,
  ffha_rsp_if.source out_ch,
  ffha_cfg_if.sink   cfg_ch
);
  import ffha_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = 16 + 16 + 1 + IW + 1;

  // Sequencer states
  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_SPLIT = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  ffha_word_t    pool_bytes_r, pool_bytes_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  ffha_word_t    req_r, req_nxt;
  ffha_word_t    sv_off_r, sv_off_nxt;
  ffha_word_t    half_r, half_nxt;
  logic [IW-1:0] sv_link_r, sv_link_nxt;
  logic          sv_has_r, sv_has_nxt;
  logic          res_granted_r, res_granted_nxt;
  ffha_word_t    res_off_r, res_off_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_granted_r, out_granted_nxt;
  ffha_word_t    out_off_r, out_off_nxt;

  // Table RAM ports
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;

  // Unpacked entry read back
  ffha_word_t    rd_off;
  ffha_word_t    rd_size;
  logic          rd_used;
  logic [IW-1:0] rd_link;
  logic          rd_has;

  ffha_word_t    half;
  ffha_dec_t     dec;
  logic          table_full;
  logic          in_acc;
  logic          cfg_acc;
  logic          out_free;

  assign rd_off  = rdata[EW-1 -: 16];
  assign rd_size = rdata[EW-17 -: 16];
  assign rd_used = rdata[IW+1];
  assign rd_link = rdata[IW:1];
  assign rd_has  = rdata[0];

  assign table_full = (count_r >= CW'(MAX_BLOCKS));

  // Handshakes
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.granted     = out_granted_r;
  assign out_ch.data_offset = out_off_r;

  ffha_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r),
    .rdata (rdata)
  );

  ffha_eval #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_eval (
    .size       (rd_size),
    .used       (rd_used),
    .req        (req_r),
    .table_full (table_full),
    .half       (half),
    .dec        (dec)
  );

  // Sequencer and table writes
  always_comb begin
    state_nxt       = state_r;
    pool_bytes_nxt  = pool_bytes_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    req_nxt         = req_r;
    sv_off_nxt      = sv_off_r;
    half_nxt        = half_r;
    sv_link_nxt     = sv_link_r;
    sv_has_nxt      = sv_has_r;
    res_granted_nxt = res_granted_r;
    res_off_nxt     = res_off_r;
    out_granted_nxt = out_granted_r;
    out_off_nxt     = out_off_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    we              = 1'b0;
    waddr           = idx_r;
    wdata           = '0;

    unique case (state_r)
      ST_INIT: begin
        // One free block covering the heap
        we        = 1'b1;
        waddr     = '0;
        wdata     = {16'd0, pool_bytes_r, 1'b0, {IW{1'b0}}, 1'b0};
        count_nxt = CW'(1);
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_acc) begin
          pool_bytes_nxt = cfg_ch.pool_bytes;
          state_nxt      = ST_INIT;
        end else if (in_acc) begin
          req_nxt   = in_ch.request_size;
          idx_nxt   = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (dec.grant) begin
          we              = 1'b1;
          wdata           = {rd_off, rd_size, 1'b1, rd_link, rd_has};
          res_granted_nxt = 1'b1;
          res_off_nxt     = rd_off + 16'(HEADER_BYTES);
          state_nxt       = ST_RESP;
        end else if (dec.split) begin
          // Shrink this block and point it at the new one
          we          = 1'b1;
          wdata       = {rd_off, half, 1'b0, count_r[IW-1:0], 1'b1};
          sv_off_nxt  = rd_off;
          half_nxt    = half;
          sv_link_nxt = rd_link;
          sv_has_nxt  = rd_has;
          state_nxt   = ST_SPLIT;
        end else if (rd_has) begin
          idx_nxt   = rd_link;
          state_nxt = ST_READ;
        end else begin
          res_granted_nxt = 1'b0;
          res_off_nxt     = '0;
          state_nxt       = ST_RESP;
        end
      end
      ST_SPLIT: begin
        // New free upper half inherits the old successor
        we        = 1'b1;
        waddr     = count_r[IW-1:0];
        wdata     = {sv_off_r + 16'(HEADER_BYTES) + half_r, half_r, 1'b0,
                     sv_link_r, sv_has_r};
        count_nxt = count_r + CW'(1);
        state_nxt = ST_READ;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = res_granted_r;
          out_off_nxt     = res_off_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      pool_bytes_r <= HEAP_RESET;
      count_r      <= CW'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pool_bytes_r <= pool_bytes_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    req_r         <= req_nxt;
    sv_off_r      <= sv_off_nxt;
    half_r        <= half_nxt;
    sv_link_r     <= sv_link_nxt;
    sv_has_r      <= sv_has_nxt;
    res_granted_r <= res_granted_nxt;
    res_off_r     <= res_off_nxt;
    out_granted_r <= out_granted_nxt;
    out_off_r     <= out_off_nxt;
  end

`ifndef SYNTHESIS
  // Table count stays within the RAM depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CW'(MAX_BLOCKS)))
    else $error("block count out of range");

  // A split only happens with a free table slot
  a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPLIT) |-> (count_r < CW'(MAX_BLOCKS)))
    else $error("split into a full table");

  // An accepted request starts a walk at the head entry
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ((state_r == ST_READ) && (idx_r == '0)))
    else $error("walk did not start at head");

  // A refused request reports a zero offset
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_granted_r) |-> (out_off_r == '0))
    else $error("failed result with nonzero offset");
`endif

endmodule

// ===== bench/ffha_checker.sv =====
// Scoreboard for the first-fit halving allocator: mirrors the block table and checks each result.
module ffha_checker #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic clk,
  input  logic rst_n,
  ffha_req_if  req_mon,
  ffha_rsp_if  rsp_mon,
  ffha_cfg_if  cfg_mon,
  output int   outstanding,
  output int   mismatches,
  output int   n_granted,
  output int   n_refused
);
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int LINK_W    = $clog2(MAX_BLOCKS);
  localparam int MAX_PRINT = 50;

  typedef struct packed {
    logic       granted;
    ffha_word_t data_offset;
  } grant_t;

  // Shadow copy of the block table
  ffha_word_t        blk_off    [MAX_BLOCKS];
  ffha_word_t        blk_size   [MAX_BLOCKS];
  logic              blk_used   [MAX_BLOCKS];
  logic [LINK_W-1:0] blk_link   [MAX_BLOCKS];
  logic              blk_linked [MAX_BLOCKS];
  int                blk_count;

  grant_t expected_grants[$];
  int     errors  = 0;
  int     grants  = 0;
  int     refusals = 0;

  // One free block spanning the whole heap
  function automatic void clear_block_table(input ffha_word_t heap_bytes);
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      blk_off[k]    = '0;
      blk_size[k]   = '0;
      blk_used[k]   = 1'b0;
      blk_link[k]   = '0;
      blk_linked[k] = 1'b0;
    end
    blk_size[0] = heap_bytes;
    blk_count   = 1;
  endfunction

  // First-fit walk with halving; updates the shadow table
  function automatic grant_t allocate_block(input ffha_word_t req);
    grant_t res;
    int     idx;
    int     half;
    int     n;
    logic   more;
    res  = '0;
    idx  = 0;
    more = 1'b1;
    while (more && idx < MAX_BLOCKS) begin
      if (!blk_used[idx] && blk_size[idx] >= req) begin
        half = (int'(blk_size[idx]) - HEADER_BYTES) / 2;
        if (blk_size[idx] != req && half >= int'(req) && half > 0 &&
            blk_count < MAX_BLOCKS) begin
          // halve and insert the upper half right after this block
          n               = blk_count;
          blk_size[idx]   = ffha_word_t'(half);
          blk_off[n]      = ffha_word_t'(int'(blk_off[idx]) + HEADER_BYTES + half);
          blk_size[n]     = ffha_word_t'(half);
          blk_used[n]     = 1'b0;
          blk_link[n]     = blk_link[idx];
          blk_linked[n]   = blk_linked[idx];
          blk_link[idx]   = LINK_W'(n);
          blk_linked[idx] = 1'b1;
          blk_count       = n + 1;
          continue;
        end
        blk_used[idx]   = 1'b1;
        res.granted     = 1'b1;
        res.data_offset = ffha_word_t'(int'(blk_off[idx]) + HEADER_BYTES);
        return res;
      end
      more = blk_linked[idx];
      idx  = int'(blk_link[idx]);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < MAX_PRINT)
      $display("[%0t] mismatch: %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Track config writes, predict on each accepted request, compare each result word
  always @(posedge clk) begin
    grant_t want;
    grant_t pred;
    if (!rst_n) begin
      clear_block_table(HEAP_RESET);
      expected_grants.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready)
        clear_block_table(cfg_mon.pool_bytes);
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("result word with no request pending", rsp_mon.data_offset, 0);
        end else begin
          want = expected_grants.pop_front();
          if (rsp_mon.granted !== want.granted)
            report_mismatch("granted", rsp_mon.granted, want.granted);
          if (rsp_mon.data_offset !== want.data_offset)
            report_mismatch("data_offset", rsp_mon.data_offset, want.data_offset);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        pred = allocate_block(req_mon.request_size);
        if (pred.granted) grants++;
        else refusals++;
        expected_grants.push_back(pred);
      end
    end
    outstanding <= expected_grants.size();
    mismatches  <= errors;
    n_granted   <= grants;
    n_refused   <= refusals;
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the allocator bench: clock, reset, request and config stimulus, result sink, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 16;

  localparam int RANDOM_ITEMS   = 1750;
  localparam int TAIL_ITEMS     = 120;
  localparam int PRESSURE_PHASE = 3;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 50;
  localparam int SETTLE_CYCLES  = 4;
  localparam int CYCLE_LIMIT    = 2_500_000;
  localparam int MAX_RUNGS      = 16;

  // Directed plan: plain entries are requests, flagged entries are pool size writes
  localparam int CFG_FLAG   = 1 << 16;
  localparam int PLAN_LEN   = 28;
  localparam int PLAN[PLAN_LEN] = '{
    0, 65535, 1, 15, 16, 17, 504,
    CFG_FLAG | 0, 0, 1,
    CFG_FLAG | 16, 0,
    CFG_FLAG | 18, 0, 1, 0,
    CFG_FLAG | 65535, 65535, 0,
    CFG_FLAG | 65535, 0, 0, 0, 32759, 40000,
    CFG_FLAG | 1024, 100, 200
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ffha_req_if in_ch ();
  ffha_rsp_if out_ch ();
  ffha_cfg_if cfg_ch ();

  int outstanding;
  int mismatches;
  int n_granted;
  int n_refused;

  // Controls shared with the result sink, driven with nonblocking writes
  int   phase_no      = 0;
  int   sink_idle_pct = 20;
  logic quiet         = 1'b0;

  // Sender-side state
  int         src_idle_pct = 20;
  logic       tail         = 1'b0;
  int         items_sent   = 0;
  int         settings     = 0;
  ffha_word_t heap_now     = HEAP_RESET;
  int         cycle_count  = 0;

  first_fit_halving_allocator_top #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  ffha_checker #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_ch),
    .rsp_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .outstanding(outstanding),
    .mismatches (mismatches),
    .n_granted  (n_granted),
    .n_refused  (n_refused)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result sink: random stall bursts, one long hold-off during the pressure phase
  initial begin : result_sink
    int   stall_left;
    int   held;
    logic pressure_done;
    stall_left    = 0;
    pressure_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!pressure_done && phase_no == PRESSURE_PHASE) begin
        pressure_done = 1'b1;
        out_ch.ready <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(99) < sink_idle_pct) begin
        stall_left = $urandom_range(13, 1);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stop offering requests, then wait until every result word has been taken
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Pool size write, only with the allocator idle
  task automatic write_heap(input ffha_word_t bytes);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.pool_bytes <= bytes;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    heap_now = bytes;
    settings++;
  endtask

  // Offer one request word, with an optional idle burst in front
  task automatic send_request(input ffha_word_t bytes);
    if (!tail && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.request_size <= bytes;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  initial begin : stimulus
    int         phase;
    int         length;
    int         pick;
    int         first_random;
    int         rungs;
    int         ladder[MAX_RUNGS];
    ffha_word_t bytes;
    in_ch.valid        <= 1'b0;
    in_ch.request_size <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.pool_bytes  <= HEAP_RESET;
    rst_n              <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: size extremes, exact fits, tiny and degenerate heaps, full refusals
    for (int k = 0; k < PLAN_LEN; k++) begin
      if ((PLAN[k] & CFG_FLAG) != 0) write_heap(ffha_word_t'(PLAN[k]));
      else send_request(ffha_word_t'(PLAN[k]));
    end

    // Random phases, each on a fresh heap
    phase        = 0;
    first_random = items_sent;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0:       bytes = '0;
        1:       bytes = 16'hFFFF;
        2:       bytes = ffha_word_t'($urandom_range(20, 16));
        3, 4:    bytes = ffha_word_t'($urandom_range(2047));
        8:       bytes = HEAP_RESET;
        9:       bytes = ffha_word_t'($urandom_range(65535, 60000));
        default: bytes = ffha_word_t'($urandom);
      endcase
      write_heap(bytes);
      phase++;
      phase_no <= phase;

      length = ($urandom_range(3) == 0) ? $urandom_range(140, 80) : $urandom_range(40, 8);
      case ($urandom_range(2))
        0:       src_idle_pct = 0;
        1:       src_idle_pct = 10;
        default: src_idle_pct = 35;
      endcase
      case ($urandom_range(2))
        0:       sink_idle_pct <= 0;
        1:       sink_idle_pct <= 10;
        default: sink_idle_pct <= 35;
      endcase
      if (phase == PRESSURE_PHASE) begin
        src_idle_pct = 0;
        if (length < 16) length = 16;
      end

      // Sizes that repeated halving of this heap produces, for exact fits
      rungs     = 1;
      ladder[0] = int'(heap_now);
      while (rungs < MAX_RUNGS && ladder[rungs-1] > HEADER_BYTES) begin
        ladder[rungs] = (ladder[rungs-1] - HEADER_BYTES) / 2;
        rungs++;
      end

      for (int n = 0; n < length && items_sent - first_random < RANDOM_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          bytes = '0;
        end else if (pick < 25) begin
          bytes = ffha_word_t'($urandom_range(15));
        end else if (pick < 55) begin
          bytes = ffha_word_t'(ladder[$urandom_range(rungs - 1)]);
          if (pick >= 48) bytes = bytes + 16'd1;
        end else if (pick < 80) begin
          bytes = ffha_word_t'($urandom_range(int'(heap_now)));
        end else begin
          bytes = ffha_word_t'($urandom_range(65535));
        end
        send_request(bytes);
        if (!tail && items_sent - first_random >= RANDOM_ITEMS - TAIL_ITEMS) begin
          tail = 1'b1;
          quiet <= 1'b1;
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests over %0d pool size writes plus reset: %0d granted, %0d refused.",
             items_sent, settings, n_granted, n_refused);
    $display("Included a %0d-cycle result stall with requests still offered.", LONG_HOLD);
    if (mismatches == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
